### rtl/core/sre_pkg.sv
// Shared types, constants and opcodes of the SimpleRISC instruction executor.
package sre_pkg;

  localparam int unsigned MemWordsDefault = 1024;
  localparam logic [31:0] SpReset = 32'd3000;

  // Request operations on the input stream.
  localparam logic [1:0] ReqWrite = 2'd0;
  localparam logic [1:0] ReqExec  = 2'd1;
  localparam logic [1:0] ReqRead  = 2'd2;
  localparam logic [1:0] ReqNone  = 2'd3;

  // Immediate modifiers; any other value sign-extends.
  localparam logic [1:0] ImmZeroExt  = 2'd1;
  localparam logic [1:0] ImmShift16  = 2'd2;

  // Instruction opcodes.
  localparam logic [4:0] OpcAdd  = 5'd0;
  localparam logic [4:0] OpcSub  = 5'd1;
  localparam logic [4:0] OpcMul  = 5'd2;
  localparam logic [4:0] OpcDiv  = 5'd3;
  localparam logic [4:0] OpcMod  = 5'd4;
  localparam logic [4:0] OpcCmp  = 5'd5;
  localparam logic [4:0] OpcAnd  = 5'd6;
  localparam logic [4:0] OpcOr   = 5'd7;
  localparam logic [4:0] OpcNot  = 5'd8;
  localparam logic [4:0] OpcMov  = 5'd9;
  localparam logic [4:0] OpcLsl  = 5'd10;
  localparam logic [4:0] OpcLsr  = 5'd11;
  localparam logic [4:0] OpcAsr  = 5'd12;
  localparam logic [4:0] OpcLd   = 5'd14;
  localparam logic [4:0] OpcSt   = 5'd15;
  localparam logic [4:0] OpcBeq  = 5'd16;
  localparam logic [4:0] OpcBgt  = 5'd17;
  localparam logic [4:0] OpcB    = 5'd18;
  localparam logic [4:0] OpcCall = 5'd19;
  localparam logic [4:0] OpcRet  = 5'd20;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RDWAIT, ST_FETCH, ST_DECODE, ST_EXEC,
    ST_DIVIDE, ST_MEMWAIT, ST_WRITEBACK, ST_OUTPUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;   // write zero at the clearing address
    logic take_req;     // latch the request fields
    logic mem_write;    // write request data to memory
    logic mem_read;     // read at request index
    logic fetch;        // read at fetch address
    logic decode;       // latch instruction word and operands
    logic exec;         // compute the result
    logic div_start;    // start the divider
    logic div_step;     // one divider step
    logic ld_read;      // read at data address
    logic st_write;     // store rd at data address
    logic writeback;    // commit result, flags and fetch address
    logic halt;         // record a halt
    logic capture_read; // latch memory data as read value
    logic load_out;     // load the output register
  } sre_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       clear_done;
    logic [1:0] op;
    logic       stopped;
    logic       instr_zero;
    logic [4:0] opcode;
    logic       div_done;
  } sre_sts_t;

endpackage

### rtl/core/sre_ram.sv
// Generic single-port RAM with registered read.
module sre_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write into the array; the registered read returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/sre_ctrl.sv
// Controller state machine of the SimpleRISC instruction executor.
module sre_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  sre_pkg::sre_sts_t sts,
  output sre_pkg::sre_cmd_t cmd
);

  sre_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == sre_pkg::ST_IDLE);

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sre_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      sre_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_nxt = sre_pkg::ST_IDLE;
      end
      sre_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.take_req = 1'b1;
          state_nxt = sre_pkg::ST_RDWAIT;
        end
      end
      sre_pkg::ST_RDWAIT: begin
        // Request fields are latched; act on the operation.
        if (sts.op == sre_pkg::ReqWrite) begin
          cmd.mem_write = 1'b1;
          state_nxt = sre_pkg::ST_OUTPUT;
        end else if (sts.op == sre_pkg::ReqExec && !sts.stopped) begin
          cmd.fetch = 1'b1;
          state_nxt = sre_pkg::ST_FETCH;
        end else begin
          cmd.mem_read = 1'b1;
          state_nxt = sre_pkg::ST_MEMWAIT;
        end
      end
      sre_pkg::ST_FETCH: begin
        cmd.decode = 1'b1;
        state_nxt = sre_pkg::ST_DECODE;
      end
      sre_pkg::ST_DECODE: begin
        if (sts.instr_zero) begin
          cmd.halt = 1'b1;
          state_nxt = sre_pkg::ST_OUTPUT;
        end else if (sts.opcode inside {sre_pkg::OpcDiv, sre_pkg::OpcMod}) begin
          cmd.div_start = 1'b1;
          state_nxt = sre_pkg::ST_DIVIDE;
        end else if (sts.opcode == sre_pkg::OpcLd) begin
          cmd.ld_read = 1'b1;
          state_nxt = sre_pkg::ST_EXEC;
        end else if (sts.opcode == sre_pkg::OpcSt) begin
          cmd.st_write = 1'b1;
          state_nxt = sre_pkg::ST_EXEC;
        end else begin
          state_nxt = sre_pkg::ST_EXEC;
        end
      end
      sre_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = sre_pkg::ST_EXEC;
      end
      sre_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = sre_pkg::ST_WRITEBACK;
      end
      sre_pkg::ST_WRITEBACK: begin
        cmd.writeback = 1'b1;
        state_nxt = sre_pkg::ST_OUTPUT;
      end
      sre_pkg::ST_MEMWAIT: begin
        cmd.capture_read = 1'b1;
        state_nxt = sre_pkg::ST_OUTPUT;
      end
      sre_pkg::ST_OUTPUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = sre_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sre_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/core/sre_dp.sv
// Datapath of the SimpleRISC instruction executor: registers, memory, ALU, divider.
module sre_dp #(
  parameter int unsigned MEM_WORDS = sre_pkg::MemWordsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        req_op,
  input  logic [9:0]        req_index,
  input  logic [31:0]       req_value,
  input  sre_pkg::sre_cmd_t cmd,
  output sre_pkg::sre_sts_t sts,
  output logic [87:0]       out_data
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned RIW = (AW < 10) ? AW : 10;

  // Request latch.
  logic [1:0]  op_r;
  logic [9:0]  idx_r;
  logic [31:0] val_r;

  // Architectural state.
  logic [31:0] rf_r [16];
  logic [11:0] pc_r;
  logic        gt_r, eq_r, stop_r;

  // Instruction and operands.
  logic [31:0] iw_r, a_r, b_r, rdv_r, res_r;
  logic [11:0] next_r;
  logic        wb_r, gt_n_r, eq_n_r;
  logic [3:0]  rd_r;

  // Clearing pass.
  logic [AW:0] clr_r;

  // Divider.
  logic [31:0] dq_r, drem_r, dmb_r;
  logic [5:0]  dcnt_r;
  logic        dna_r, dnb_r, dzero_r;
  logic [32:0] dtrial;

  // Memory port.
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic [31:0]   data_addr;

  // Output register.
  logic [11:0] o_pc_r;
  logic        o_halt_r, o_wr_r, o_gt_r, o_eq_r;
  logic [3:0]  o_idx_r;
  logic [31:0] o_val_r, o_read_r, readv_r;

  // Pc of the instruction executed and whether a write was committed.
  logic        iw_valid_r, exec_wb_r;
  logic [11:0] iw_pc_r;

  // Decode.
  logic [4:0]  opc;
  logic [31:0] dec_imm, off;

  // Execute unit.
  logic [31:0] res_c;
  logic [11:0] next_c;
  logic        wb_c, gt_c, eq_c;
  logic [3:0]  rd_c;
  logic [11:0] seq_pc, br_pc;
  logic        big_sh;
  logic [31:0] q_fix, r_fix;

  assign data_addr = a_r + b_r;

  // Memory address and write selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = AW'(req_index);
    if (cmd.clear_step) begin
      mem_we   = 1'b1;
      mem_addr = clr_r[AW-1:0];
    end else if (cmd.mem_write || cmd.mem_read) begin
      mem_we    = cmd.mem_write;
      mem_wdata = val_r;
      mem_addr  = AW'(idx_r[RIW-1:0]);
    end else if (cmd.fetch) begin
      mem_addr = AW'(pc_r[11:2]);
    end else if (cmd.ld_read || cmd.st_write) begin
      mem_we    = cmd.st_write;
      mem_wdata = rdv_r;
      mem_addr  = data_addr[AW+1:2];
    end
  end

  sre_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_step && !clr_r[AW]) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      op_r  <= req_op;
      idx_r <= req_index;
      val_r <= req_value;
    end
  end

  // Immediate of the word on the read port, taken while decoding.
  always_comb begin
    case (mem_rdata[17:16])
      sre_pkg::ImmZeroExt: dec_imm = {16'h0, mem_rdata[15:0]};
      sre_pkg::ImmShift16: dec_imm = {mem_rdata[15:0], 16'h0};
      default:             dec_imm = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
    endcase
  end

  assign opc = iw_r[31:27];
  assign off = {{3{iw_r[26]}}, iw_r[26:0], 2'b00};

  assign seq_pc = pc_r + 12'd4;
  assign br_pc  = pc_r + off[11:0];
  assign big_sh = |b_r[31:5];
  assign q_fix  = dzero_r ? 32'h0 : ((dna_r ^ dnb_r) ? (32'h0 - dq_r) : dq_r);
  assign r_fix  = dzero_r ? 32'h0 : (dna_r ? (32'h0 - drem_r) : drem_r);

  always_comb begin
    res_c  = '0;
    wb_c   = 1'b1;
    gt_c   = gt_r;
    eq_c   = eq_r;
    rd_c   = iw_r[25:22];
    next_c = seq_pc;
    case (opc)
      sre_pkg::OpcAdd: res_c = a_r + b_r;
      sre_pkg::OpcSub: res_c = a_r - b_r;
      sre_pkg::OpcMul: res_c = a_r * b_r;
      sre_pkg::OpcDiv: res_c = q_fix;
      sre_pkg::OpcMod: res_c = r_fix;
      sre_pkg::OpcCmp: begin
        wb_c = 1'b0;
        gt_c = $signed(a_r) > $signed(b_r);
        eq_c = (a_r == b_r);
      end
      sre_pkg::OpcAnd: res_c = a_r & b_r;
      sre_pkg::OpcOr:  res_c = a_r | b_r;
      sre_pkg::OpcNot: res_c = ~b_r;
      sre_pkg::OpcMov: res_c = b_r;
      sre_pkg::OpcLsl: res_c = big_sh ? 32'h0 : (a_r << b_r[4:0]);
      sre_pkg::OpcLsr: res_c = big_sh ? 32'h0 : (a_r >> b_r[4:0]);
      sre_pkg::OpcAsr: res_c = big_sh ? {32{a_r[31]}} : 32'($signed(a_r) >>> b_r[4:0]);
      sre_pkg::OpcLd:  res_c = mem_rdata;
      sre_pkg::OpcSt:  wb_c = 1'b0;
      sre_pkg::OpcBeq: begin wb_c = 1'b0; if (eq_r) next_c = br_pc; end
      sre_pkg::OpcBgt: begin wb_c = 1'b0; if (gt_r) next_c = br_pc; end
      sre_pkg::OpcB:   begin wb_c = 1'b0; next_c = br_pc; end
      sre_pkg::OpcCall: begin
        res_c  = {20'h0, seq_pc};
        rd_c   = 4'd15;
        next_c = br_pc;
      end
      sre_pkg::OpcRet: begin wb_c = 1'b0; next_c = a_r[11:0]; end
      default: wb_c = 1'b0;
    endcase
  end

  // Decode and execute registers; operand b takes the immediate when flagged.
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      iw_r  <= mem_rdata;
      a_r   <= (mem_rdata[31:27] == sre_pkg::OpcRet) ? rf_r[15] : rf_r[mem_rdata[21:18]];
      rdv_r <= rf_r[mem_rdata[25:22]];
      if (mem_rdata[26]) begin
        b_r <= dec_imm;
      end else if (mem_rdata[31:27] == sre_pkg::OpcSt) begin
        b_r <= rf_r[mem_rdata[25:22]];
      end else begin
        b_r <= rf_r[mem_rdata[17:14]];
      end
    end else if (cmd.exec) begin
      res_r  <= res_c;
      wb_r   <= wb_c;
      rd_r   <= rd_c;
      gt_n_r <= gt_c;
      eq_n_r <= eq_c;
      next_r <= next_c;
    end
  end

  // Divider: restoring, one quotient bit per step on magnitudes.
  assign dtrial = {drem_r, dq_r[31]} - {1'b0, dmb_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dna_r   <= a_r[31];
      dnb_r   <= b_r[31];
      dzero_r <= (b_r == 32'h0);
      dq_r    <= a_r[31] ? (32'h0 - a_r) : a_r;
      dmb_r   <= b_r[31] ? (32'h0 - b_r) : b_r;
      drem_r  <= '0;
      dcnt_r  <= 6'd0;
    end else if (cmd.div_step && !dcnt_r[5]) begin
      if (!dtrial[32]) begin
        drem_r <= dtrial[31:0];
        dq_r   <= {dq_r[30:0], 1'b1};
      end else begin
        drem_r <= {drem_r[30:0], dq_r[31]};
        dq_r   <= {dq_r[30:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // Architectural state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) rf_r[i] <= (i == 14) ? sre_pkg::SpReset : 32'h0;
      pc_r   <= '0;
      gt_r   <= 1'b0;
      eq_r   <= 1'b0;
      stop_r <= 1'b0;
    end else begin
      if (cmd.halt) stop_r <= 1'b1;
      if (cmd.writeback) begin
        if (wb_r) rf_r[rd_r] <= res_r;
        gt_r <= gt_n_r;
        eq_r <= eq_n_r;
        pc_r <= next_r;
      end
    end
  end

  // Read value and output register.
  always_ff @(posedge clk) begin
    if (cmd.take_req) readv_r <= '0;
    if (cmd.capture_read) readv_r <= (op_r == sre_pkg::ReqRead) ? mem_rdata : 32'h0;
    if (cmd.load_out) begin
      o_pc_r   <= (op_r == sre_pkg::ReqExec && iw_valid_r) ? iw_pc_r : pc_r;
      o_halt_r <= stop_r;
      o_wr_r   <= exec_wb_r;
      o_idx_r  <= exec_wb_r ? rd_r : 4'd0;
      o_val_r  <= exec_wb_r ? res_r : 32'h0;
      o_gt_r   <= gt_r;
      o_eq_r   <= eq_r;
      o_read_r <= readv_r;
    end
  end

  // Track the executed instruction of the current request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_valid_r <= 1'b0;
      exec_wb_r  <= 1'b0;
    end else begin
      if (cmd.take_req) begin
        iw_valid_r <= 1'b0;
        exec_wb_r  <= 1'b0;
      end
      if (cmd.writeback) begin
        iw_valid_r <= 1'b1;
        iw_pc_r    <= pc_r;
        exec_wb_r  <= wb_r;
      end
    end
  end

  assign sts.clear_done = clr_r[AW];
  assign sts.op         = op_r;
  assign sts.stopped    = stop_r;
  assign sts.instr_zero = (iw_r == 32'h0);
  assign sts.opcode     = opc;
  assign sts.div_done   = dcnt_r[5];

  // Fields from the lowest bit: pc_now, halted, reg_written, reg_index, reg_value,
  // greater_flag, equal_flag, read_value, zero fill.
  assign out_data = {4'd0, o_read_r, o_eq_r, o_gt_r, o_val_r, o_idx_r, o_wr_r, o_halt_r,
                     o_pc_r};

endmodule

### rtl/core/simplerisc_instruction_executor.sv
// Top level of the SimpleRISC instruction executor.
// Each request (memory write, memory read, halting fetch, instruction, divide or
// modulo through the restoring divider) is finished before the next is taken.
// Throughput: one request at a time, the next taken in the cycle after the result is
// loaded, plus any wait for a held result.
// Reset: synchronous, active low; a clearing pass over all MEM_WORDS words zeroes
// the memory before the first request is accepted.
module simplerisc_instruction_executor #(
  parameter int unsigned MEM_WORDS = sre_pkg::MemWordsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op[1:0], word_index[11:2], write_value[43:12], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata   // pc_now[11:0], halted[12], reg_written[13],
                                  // reg_index[17:14], reg_value[49:18], greater_flag[50],
                                  // equal_flag[51], read_value[83:52], zero fill
);

  sre_pkg::sre_cmd_t cmd;
  sre_pkg::sre_sts_t sts;

  sre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sre_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_op   (in_tdata[1:0]),
    .req_index(in_tdata[11:2]),
    .req_value(in_tdata[43:12]),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule

### rtl/core/sre_checker.sv
// Port-level assertions for the SimpleRISC instruction executor, bound to the top level.
module sre_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);

  // A result held back keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // No request is taken straight after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // Halt stays set once reported.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[12] ##1 out_tvalid |-> out_tdata[12])
    else $error("halt flag cleared");

  // No result straight after reset.
  a_no_result_in_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

endmodule

bind simplerisc_instruction_executor sre_checker u_sre_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

### sim/simplerisc_instruction_executor_tb.sv
// Self-checking testbench for the SimpleRISC instruction executor.
module simplerisc_instruction_executor_tb;

  localparam int unsigned Words = sre_pkg::MemWordsDefault;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandomItems = 1300;

  // One result of the executor, field by field.
  typedef struct {
    logic [11:0] pc_now;
    logic        halted;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic        greater_flag;
    logic        equal_flag;
    logic [31:0] read_value;
  } step_result_t;

  // One row of the directed part; typed_ok marks a row whose result is typed in.
  typedef struct {
    logic [1:0]   op;
    logic [9:0]   word_index;
    logic [31:0]  write_value;
    bit           typed_ok;
    step_result_t typed;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;

  // Shadow copy of the processor state.
  logic [31:0] shadow_regs [16];
  logic [31:0] shadow_mem [Words];
  logic [11:0] shadow_fetch;
  logic        shadow_gt;
  logic        shadow_eq;
  logic        shadow_stopped;

  step_result_t pending_results [$];
  int unsigned  cycle_count = 0;
  int unsigned  mismatches = 0;
  int unsigned  ready_hold;
  bit           quiet_phase;

  simplerisc_instruction_executor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Clock with a period of 8.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Signed division as the processor defines it: zero divisor gives zero.
  function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b,
                                       input bit want_rem);
    logic [31:0] ma;
    logic [31:0] mb;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    if (b == 32'd0) return 32'd0;
    if (want_rem) return a[31] ? -(ma % mb) : (ma % mb);
    return (a[31] ^ b[31]) ? -(ma / mb) : (ma / mb);
  endfunction

  // Works out the result of one request and advances the shadow state.
  task automatic execute_request(input logic [1:0] op, input logic [9:0] idx,
                                 input logic [31:0] wval, output step_result_t res);
    logic [31:0] iw;
    logic [4:0]  opc;
    logic [3:0]  rd;
    logic [31:0] imm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] val;
    logic [31:0] off;
    logic [31:0] addr;
    logic [11:0] next_pc;
    bit          wb;
    res = '{default: '0};
    res.pc_now = shadow_fetch;
    if (op == sre_pkg::ReqWrite) begin
      shadow_mem[idx] = wval;
    end else if (op == sre_pkg::ReqRead) begin
      res.read_value = shadow_mem[idx];
    end else if (op == sre_pkg::ReqExec && !shadow_stopped) begin
      iw = shadow_mem[shadow_fetch[11:2]];
      if (iw == 32'd0) begin
        shadow_stopped = 1'b1;
      end else begin
        opc = iw[31:27];
        rd = iw[25:22];
        wb = 1'b0;
        val = 32'd0;
        next_pc = shadow_fetch + 12'd4;
        case (iw[17:16])
          sre_pkg::ImmZeroExt: imm = {16'd0, iw[15:0]};
          sre_pkg::ImmShift16: imm = {iw[15:0], 16'd0};
          default: imm = {{16{iw[15]}}, iw[15:0]};
        endcase
        a = (opc == sre_pkg::OpcRet) ? shadow_regs[15] : shadow_regs[iw[21:18]];
        b = iw[26] ? imm : shadow_regs[(opc == sre_pkg::OpcSt) ? rd : iw[17:14]];
        off = {{3{iw[26]}}, iw[26:0], 2'b00};
        addr = a + b;
        case (opc)
          sre_pkg::OpcAdd: begin val = a + b; wb = 1'b1; end
          sre_pkg::OpcSub: begin val = a - b; wb = 1'b1; end
          sre_pkg::OpcMul: begin val = a * b; wb = 1'b1; end
          sre_pkg::OpcDiv: begin val = sdiv(a, b, 1'b0); wb = 1'b1; end
          sre_pkg::OpcMod: begin val = sdiv(a, b, 1'b1); wb = 1'b1; end
          sre_pkg::OpcCmp: begin
            shadow_gt = $signed(a) > $signed(b);
            shadow_eq = (a == b);
          end
          sre_pkg::OpcAnd: begin val = a & b; wb = 1'b1; end
          sre_pkg::OpcOr:  begin val = a | b; wb = 1'b1; end
          sre_pkg::OpcNot: begin val = ~b; wb = 1'b1; end
          sre_pkg::OpcMov: begin val = b; wb = 1'b1; end
          sre_pkg::OpcLsl: begin val = (b >= 32) ? 32'd0 : a << b[4:0]; wb = 1'b1; end
          sre_pkg::OpcLsr: begin val = (b >= 32) ? 32'd0 : a >> b[4:0]; wb = 1'b1; end
          sre_pkg::OpcAsr: begin
            val = (b >= 32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
            wb = 1'b1;
          end
          sre_pkg::OpcLd:  begin val = shadow_mem[addr[11:2]]; wb = 1'b1; end
          sre_pkg::OpcSt:  shadow_mem[addr[11:2]] = shadow_regs[rd];
          sre_pkg::OpcBeq: if (shadow_eq) next_pc = shadow_fetch + off[11:0];
          sre_pkg::OpcBgt: if (shadow_gt) next_pc = shadow_fetch + off[11:0];
          sre_pkg::OpcB:   next_pc = shadow_fetch + off[11:0];
          sre_pkg::OpcCall: begin
            val = {20'd0, shadow_fetch + 12'd4};
            rd = 4'd15;
            wb = 1'b1;
            next_pc = shadow_fetch + off[11:0];
          end
          sre_pkg::OpcRet: next_pc = a[11:0];
          default: ;
        endcase
        if (wb) begin
          shadow_regs[rd] = val;
          res.reg_written = 1'b1;
          res.reg_index = rd;
          res.reg_value = val;
        end
        shadow_fetch = next_pc;
      end
    end
    res.halted = shadow_stopped;
    res.greater_flag = shadow_gt;
    res.equal_flag = shadow_eq;
  endtask

  // Offers one request, waits for it to be taken, and queues its expected result.
  task automatic send_request(input logic [1:0] op, input logic [9:0] idx,
                              input logic [31:0] wval, input bit typed_ok,
                              input step_result_t typed);
    step_result_t res;
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, wval, idx, op};
    do @(posedge clk); while (!in_tready);
    execute_request(op, idx, wval, res);
    pending_results.push_back(typed_ok ? typed : res);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] encode(input logic [4:0] opc, input bit use_imm,
                                         input logic [3:0] rd, input logic [3:0] rs1,
                                         input logic [17:0] tail);
    return {opc, use_imm, rd, rs1, tail};
  endfunction

  function automatic logic [31:0] random_instr();
    logic [31:0] iw;
    if ($urandom_range(0, 5) == 0) iw = {5'($urandom_range(0, 31)), 27'($urandom)};
    else iw = {5'($urandom_range(0, 20)), 27'($urandom)};
    if ($urandom_range(0, 2) == 0) iw[15:0] = 16'($urandom_range(0, 40));
    return (iw == 32'd0) ? 32'd1 : iw;
  endfunction

  // Receiver side: random stalls in bursts, none in the quiet phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    step_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no expectation: %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[11:0] !== want.pc_now) begin
          $error("pc_now expected %h actual %h", want.pc_now, out_tdata[11:0]);
          mismatches++;
        end
        if (out_tdata[12] !== want.halted) begin
          $error("halted expected %b actual %b", want.halted, out_tdata[12]);
          mismatches++;
        end
        if (out_tdata[13] !== want.reg_written) begin
          $error("reg_written expected %b actual %b", want.reg_written, out_tdata[13]);
          mismatches++;
        end
        if (out_tdata[17:14] !== want.reg_index) begin
          $error("reg_index expected %h actual %h", want.reg_index, out_tdata[17:14]);
          mismatches++;
        end
        if (out_tdata[49:18] !== want.reg_value) begin
          $error("reg_value expected %h actual %h", want.reg_value, out_tdata[49:18]);
          mismatches++;
        end
        if (out_tdata[50] !== want.greater_flag) begin
          $error("greater_flag expected %b actual %b", want.greater_flag, out_tdata[50]);
          mismatches++;
        end
        if (out_tdata[51] !== want.equal_flag) begin
          $error("equal_flag expected %b actual %b", want.equal_flag, out_tdata[51]);
          mismatches++;
        end
        if (out_tdata[83:52] !== want.read_value) begin
          $error("read_value expected %h actual %h", want.read_value, out_tdata[83:52]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    stim_row_t    rows [$];
    stim_row_t    row;
    step_result_t blank;
    logic [31:0]  program_words [8];
    int unsigned  sent;
    int unsigned  pick;
    bit           paused;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    quiet_phase = 1'b0;
    for (int i = 0; i < 16; i++) shadow_regs[i] = 32'd0;
    shadow_regs[14] = sre_pkg::SpReset;
    for (int i = 0; i < Words; i++) shadow_mem[i] = 32'd0;
    shadow_fetch = '0;
    shadow_gt = 1'b0;
    shadow_eq = 1'b0;
    shadow_stopped = 1'b0;
    blank = '{default: '0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed program: sign, shift-high, overflowing divide, saturating shift,
    // divide by zero, equal compare, taken branch and return.
    program_words[0] = encode(sre_pkg::OpcMov, 1'b1, 4'd1, 4'd0, 18'h0ffff);
    program_words[1] = encode(sre_pkg::OpcMov, 1'b1, 4'd3, 4'd0, 18'h28000);
    program_words[2] = encode(sre_pkg::OpcDiv, 1'b0, 4'd6, 4'd3, {4'd1, 14'd0});
    program_words[3] = encode(sre_pkg::OpcLsr, 1'b1, 4'd7, 4'd1, 18'd32);
    program_words[4] = encode(sre_pkg::OpcMod, 1'b1, 4'd4, 4'd1, 18'd0);
    program_words[5] = encode(sre_pkg::OpcCmp, 1'b0, 4'd0, 4'd1, {4'd1, 14'd0});
    program_words[6] = {sre_pkg::OpcBeq, 27'd2};
    program_words[7] = encode(sre_pkg::OpcRet, 1'b0, 4'd0, 4'd0, 18'd0);
    row = '{sre_pkg::ReqRead, 10'd1023, 32'hffff_ffff, 1'b1, blank};
    rows.push_back(row);
    for (int i = 0; i < 7; i++) begin
      row = '{sre_pkg::ReqWrite, 10'(i), program_words[i], 1'b1, blank};
      rows.push_back(row);
    end
    row = '{sre_pkg::ReqWrite, 10'd8, program_words[7], 1'b1, blank};
    rows.push_back(row);
    for (int i = 0; i < 8; i++) begin
      row = '{sre_pkg::ReqExec, 10'd0, 32'd0, 1'b0, blank};
      rows.push_back(row);
    end
    row = '{sre_pkg::ReqNone, 10'h2aa, 32'h5555_aaaa, 1'b0, blank};
    rows.push_back(row);
    row = '{sre_pkg::ReqRead, 10'd3, 32'd0, 1'b0, blank};
    rows.push_back(row);
    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].word_index, rows[i].write_value,
                   rows[i].typed_ok, rows[i].typed);
    end

    // Random part: mostly execution of freshly loaded instructions.
    sent = 0;
    paused = 1'b0;
    while (sent < RandomItems) begin
      if (!paused && sent >= RandomItems / 2) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      if (sent >= RandomItems - 150) quiet_phase = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        if (shadow_mem[shadow_fetch[11:2]] == 32'd0 || $urandom_range(0, 1) == 0) begin
          send_request(sre_pkg::ReqWrite, shadow_fetch[11:2], random_instr(), 1'b0, blank);
          sent++;
        end
        send_request(sre_pkg::ReqExec, 10'($urandom), $urandom, 1'b0, blank);
      end else if (pick < 17) begin
        send_request(sre_pkg::ReqWrite, 10'($urandom), $urandom, 1'b0, blank);
      end else if (pick < 19) begin
        send_request(sre_pkg::ReqRead, 10'($urandom), $urandom, 1'b0, blank);
      end else begin
        send_request(sre_pkg::ReqNone, 10'($urandom), $urandom, 1'b0, blank);
      end
      sent++;
    end

    // Halt on a zero word, then check that execution stays stopped.
    send_request(sre_pkg::ReqWrite, shadow_fetch[11:2], 32'd0, 1'b0, blank);
    send_request(sre_pkg::ReqExec, 10'd0, 32'd0, 1'b0, blank);
    send_request(sre_pkg::ReqExec, 10'd0, 32'd0, 1'b0, blank);
    send_request(sre_pkg::ReqWrite, 10'd7, 32'h1234_5678, 1'b0, blank);
    send_request(sre_pkg::ReqRead, 10'd7, 32'd0, 1'b0, blank);
    in_tvalid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
